/* hdl/vdir_pkg.sv */
// ----------------------------------------------------------------------------
// vdir_pkg
// Shared types and defaults for the vertex welding and index remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package vdir_pkg;

   // default table depth and the widths that follow from it
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int IDX_W_DEF       = $clog2(TABLE_DEPTH_DEF);
   localparam int CNT_W_DEF       = $clog2(TABLE_DEPTH_DEF + 1);

   // coordinate word and result index widths on the channels
   localparam int COORD_W = 32;
   localparam int OUT_W   = 9;

   // one vertex as three raw coordinate words
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } vertex_type;

   // probe travelling along the cell row
   typedef struct packed {
      logic       last;
      logic       hit;
      vertex_type vertex;
   } probe_type;

   // append port broadcast to all cells
   typedef struct packed {
      logic       en;
      vertex_type vertex;
   } write_type;

   // one result beat
   typedef struct packed {
      logic [OUT_W-1:0] new_index;
      logic             is_new;
      logic             overflow;
      logic [OUT_W-1:0] unique_count;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/vdir_req_if.sv */
// ----------------------------------------------------------------------------
// vdir_req_if
// Vertex request channel: valid/ready with three coordinate words.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdir_req_if;
   import vdir_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   logic [COORD_W-1:0] coord_z;
   logic               last_vertex;

   modport source (
      output valid, coord_x, coord_y, coord_z, last_vertex,
      input  ready
   );

   modport sink (
      input  valid, coord_x, coord_y, coord_z, last_vertex,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/vdir_rsp_if.sv */
// ----------------------------------------------------------------------------
// vdir_rsp_if
// Remap result channel: valid/ready with index, flags and unique count.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdir_rsp_if;
   import vdir_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] new_index;
   logic             is_new;
   logic             overflow;
   logic [OUT_W-1:0] unique_count;

   modport source (
      output valid, new_index, is_new, overflow, unique_count,
      input  ready
   );

   modport sink (
      input  valid, new_index, is_new, overflow, unique_count,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/vdir_cell.sv */
// ----------------------------------------------------------------------------
// vdir_cell
// One table slot: holds a stored vertex, compares the passing probe against
// it and hands the probe on to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdir_cell #(
   parameter int IDX_W = vdir_pkg::IDX_W_DEF,
   parameter int CNT_W = vdir_pkg::CNT_W_DEF,
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   input  wire vdir_pkg::probe_type   up_probe,
   input  wire logic [IDX_W-1:0]      up_idx,
   output logic                       dn_valid,
   output vdir_pkg::probe_type        dn_probe,
   output logic [IDX_W-1:0]           dn_idx,
   input  wire vdir_pkg::write_type   wr,
   input  wire logic [IDX_W-1:0]      wr_idx,
   input  wire logic [CNT_W-1:0]      fill_count
);
   import vdir_pkg::*;

   vertex_type       entry_ff;
   logic             valid_ff;
   probe_type        probe_ff, probe_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             live;
   logic             match;

   // stored vertex, loaded on append to this slot
   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx == IDX_W'(INDEX))) begin
         entry_ff <= wr.vertex;
      end
   end

   // compare only slots below the fill count
   always_comb begin
      live      = (CNT_W'(INDEX) < fill_count);
      match     = live && (entry_ff == up_probe.vertex);
      probe_in  = up_probe;
      probe_in.hit = up_probe.hit | match;
      idx_in    = up_probe.hit ? up_idx : IDX_W'(INDEX);
   end

   // probe stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   // probe stage payload
   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      idx_ff   <= idx_in;
   end

   assign dn_valid = valid_ff;
   assign dn_probe = probe_ff;
   assign dn_idx   = idx_ff;

endmodule

`default_nettype wire

/* hdl/vdir_chain.sv */
// ----------------------------------------------------------------------------
// vdir_chain
// Row of table cells; a probe enters at slot zero and leaves after the last
// slot carrying the first matching index.
// ----------------------------------------------------------------------------
`default_nettype none

module vdir_chain #(
   parameter int TABLE_DEPTH = vdir_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = vdir_pkg::IDX_W_DEF,
   parameter int CNT_W       = vdir_pkg::CNT_W_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   input  wire vdir_pkg::probe_type   up_probe,
   output logic                       dn_valid,
   output vdir_pkg::probe_type        dn_probe,
   output logic [IDX_W-1:0]           dn_idx,
   input  wire vdir_pkg::write_type   wr,
   input  wire logic [IDX_W-1:0]      wr_idx,
   input  wire logic [CNT_W-1:0]      fill_count
);
   import vdir_pkg::*;

   logic             link_valid [0:TABLE_DEPTH];
   probe_type        link_probe [0:TABLE_DEPTH];
   logic [IDX_W-1:0] link_idx   [0:TABLE_DEPTH];

   // head of the row
   assign link_valid[0] = up_valid;
   assign link_probe[0] = up_probe;
   assign link_idx[0]   = '0;

   // one cell per table slot
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      vdir_cell #(
         .IDX_W (IDX_W),
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[i]),
         .up_probe   (link_probe[i]),
         .up_idx     (link_idx[i]),
         .dn_valid   (link_valid[i+1]),
         .dn_probe   (link_probe[i+1]),
         .dn_idx     (link_idx[i+1]),
         .wr         (wr),
         .wr_idx     (wr_idx),
         .fill_count (fill_count)
      );
   end

   // tail of the row
   assign dn_valid = link_valid[TABLE_DEPTH];
   assign dn_probe = link_probe[TABLE_DEPTH];
   assign dn_idx   = link_idx[TABLE_DEPTH];

endmodule

`default_nettype wire

/* hdl/vertex_dedup_index_remap.sv */
// ----------------------------------------------------------------------------
// vertex_dedup_index_remap
// Streaming vertex welding: returns the compacted index of each vertex.
// ----------------------------------------------------------------------------
// Usage
//   req_chan (sink): one beat per vertex, three 32-bit coordinate words and
//   last_vertex. rsp_chan (source): one beat per vertex with new_index,
//   is_new, overflow and unique_count, in request order.
//   A vertex equal in all three words to a stored one gets that entry's
//   index; otherwise it is appended at the next free slot. With the table
//   full and no match, new_index is TABLE_DEPTH and overflow is set. After
//   a beat with last_vertex the table is empty again.
// Timing
//   The probe walks the cell row one slot per cycle; its result is registered
//   as it leaves the last cell, and a new vertex is taken only once the
//   previous probe has left the row.
//   A result register plus one skid entry sit on the output: a stalled
//   receiver does not hold back the next vertex, and requests stop only
//   once a second result is waiting.
// Reset
//   Synchronous, active high: empties the table (fill count to zero) and
//   drops any vertex in flight or result waiting. Stored words are kept but
//   never compared until written again.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_dedup_index_remap #(
   parameter int TABLE_DEPTH = vdir_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   vdir_req_if.sink   req_chan,
   vdir_rsp_if.source rsp_chan
);
   import vdir_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WIDE_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;
   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
   localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(TABLE_DEPTH);

   logic             req_fire;
   logic             rsp_fire;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   probe_type        head_probe;
   logic             tail_valid;
   probe_type        tail_probe;
   logic [IDX_W-1:0] tail_idx;
   write_type        wr;
   logic [IDX_W-1:0] wr_idx;
   logic [CNT_W-1:0] dec_idx;
   logic [CNT_W-1:0] dec_count;
   logic [WIDE_W-1:0] idx_wide;
   logic [WIDE_W-1:0] count_wide;
   rsp_type          dec;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             skid_valid_ff, skid_valid_in;
   rsp_type          skid_ff, skid_in;

   // request handshake: one vertex in the row at a time
   assign req_chan.ready = !busy_ff && !skid_valid_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      head_probe.last     = req_chan.last_vertex;
      head_probe.hit      = 1'b0;
      head_probe.vertex.x = req_chan.coord_x;
      head_probe.vertex.y = req_chan.coord_y;
      head_probe.vertex.z = req_chan.coord_z;
   end

   // cell row
   vdir_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_fire),
      .up_probe   (head_probe),
      .dn_valid   (tail_valid),
      .dn_probe   (tail_probe),
      .dn_idx     (tail_idx),
      .wr         (wr),
      .wr_idx     (wr_idx),
      .fill_count (fill_count_ff)
   );

   // decide hit, append or overflow as the probe leaves the row
   always_comb begin
      wr.en         = 1'b0;
      wr.vertex     = tail_probe.vertex;
      wr_idx        = fill_count_ff[IDX_W-1:0];
      dec_idx       = fill_count_ff;
      dec_count     = fill_count_ff;
      dec.is_new    = 1'b0;
      dec.overflow  = 1'b0;
      if (tail_probe.hit) begin
         dec_idx = CNT_W'(tail_idx);
      end else if (fill_count_ff < DEPTH_CNT) begin
         wr.en      = tail_valid;
         dec_count  = CNT_W'(fill_count_ff + 1'b1);
         dec.is_new = 1'b1;
      end else begin
         dec_idx      = DEPTH_CNT;
         dec.overflow = 1'b1;
      end
      idx_wide         = WIDE_W'(dec_idx);
      count_wide       = WIDE_W'(dec_count);
      dec.new_index    = idx_wide[OUT_W-1:0];
      dec.unique_count = count_wide[OUT_W-1:0];

      fill_count_in = fill_count_ff;
      if (tail_valid) begin
         fill_count_in = tail_probe.last ? '0 : dec_count;
      end
   end

   // busy while a probe is in the row
   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (tail_valid) begin
         busy_in = 1'b0;
      end
   end

   // result register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (skid_valid_ff && !rsp_valid_in) begin
         rsp_in        = skid_ff;
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (tail_valid) begin
         if (rsp_valid_in) begin
            skid_in       = dec;
            skid_valid_in = 1'b1;
         end else begin
            rsp_in       = dec;
            rsp_valid_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.new_index    = rsp_ff.new_index;
   assign rsp_chan.is_new       = rsp_ff.is_new;
   assign rsp_chan.overflow     = rsp_ff.overflow;
   assign rsp_chan.unique_count = rsp_ff.unique_count;

`ifndef ASSERT_OFF
   // a waiting skid entry always sits behind a shown result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result beat in front");

   // a probe only leaves the row when one was taken in
   a_tail_when_busy: assert property (@(posedge clock) disable iff (reset)
      tail_valid |-> busy_ff)
      else $error("probe left the cell row while idle");

   // fill count never passes the table depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DEPTH_CNT)
      else $error("fill count beyond table depth");

   // overflow beats report a full table and no append
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overflow) |->
         (!rsp_ff.is_new && (rsp_ff.unique_count == DEPTH_WIDE[OUT_W-1:0])))
      else $error("overflow beat with inconsistent count or append flag");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Vertex welding testbench: a short table of hand-picked vertices, then
// random sets of vertices with repeats, near misses and table overflow.
// Every result beat is compared field by field with a local welding model
// or hand-typed want, under three patterns of idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
   import vdir_pkg::*;

   localparam int DEPTH          = TABLE_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 8 * (DEPTH + 1) + 2000;
   localparam int DRAIN_CYCLES   = DEPTH + 32;
   localparam int PHASE_ITEMS    = 384;
   localparam int MAX_REPORTS    = 10;

   // one row of the directed table
   typedef struct packed {
      vertex_type v;
      logic       last;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   // hand-typed expectation travelling with each request beat
   typedef struct {
      bit      typed;
      rsp_type want;
   } hand_exp_type;

   logic clock;
   logic reset;

   vdir_req_if req_bus ();
   vdir_rsp_if rsp_bus ();

   vertex_dedup_index_remap dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // welding model state
   vertex_type weld_tbl [DEPTH];
   int         weld_fill;

   rsp_type      remap_q [$];
   hand_exp_type hand_q [$];

   int send_idle_pct;
   int sink_idle_pct;
   int random_items;
   int vertices_sent;
   int sets_closed;
   int results_checked;
   int dup_seen;
   int overflow_seen;
   int error_cnt;
   int idle_cycles;

   // directed vertices: extremes, repeats, one-word differences, set ends
   dir_row_type dir_rows [0:17] = '{
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 1'b1,
        '{9'd0, 1'b1, 1'b0, 9'd1}},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 1'b1,
        '{9'd1, 1'b1, 1'b0, 9'd2}},
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 1'b1,
        '{9'd0, 1'b0, 1'b0, 9'd2}},
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b0, 1'b1,
        '{9'd2, 1'b1, 1'b0, 9'd3}},
      '{'{32'h0000_0000, 32'h0000_0001, 32'h0000_0000}, 1'b0, 1'b1,
        '{9'd3, 1'b1, 1'b0, 9'd4}},
      '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000}, 1'b0, 1'b1,
        '{9'd4, 1'b1, 1'b0, 9'd5}},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE}, 1'b0, 1'b1,
        '{9'd5, 1'b1, 1'b0, 9'd6}},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, 1'b1,
        '{9'd6, 1'b1, 1'b0, 9'd7}},
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b0, 1'b1,
        '{9'd2, 1'b0, 1'b0, 9'd7}},
      // last beat on a repeat, table empties afterwards
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 1'b1,
        '{9'd1, 1'b0, 1'b0, 9'd7}},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 1'b1,
        '{9'd0, 1'b1, 1'b0, 9'd1}},
      // last beat on a new vertex
      '{'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9}, 1'b1, 1'b1,
        '{9'd1, 1'b1, 1'b0, 9'd2}},
      // single-vertex set
      '{'{32'h0000_0005, 32'h0000_0005, 32'h0000_0005}, 1'b1, 1'b1,
        '{9'd0, 1'b1, 1'b0, 9'd1}},
      '{'{32'h0000_0005, 32'h0000_0005, 32'h0000_0005}, 1'b0, 1'b1,
        '{9'd0, 1'b1, 1'b0, 9'd1}},
      '{'{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3C3C_3C3C}, 1'b0, 1'b0, '0},
      '{'{32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h3C3C_3C3C}, 1'b0, 1'b0, '0},
      '{'{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3C3C_3C3C}, 1'b0, 1'b0, '0},
      '{'{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, 1'b0, '0}
   };

   // welding model: look up, append or overflow, then clear on last
   function automatic rsp_type weld_vertex(input vertex_type v, input logic last);
      rsp_type r;
      bit      hit;
      int      slot;
      r    = '0;
      hit  = 1'b0;
      slot = 0;
      for (int i = 0; i < weld_fill; i++) begin
         if (!hit && weld_tbl[i] == v) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         r.new_index = OUT_W'(slot);
      end else if (weld_fill < DEPTH) begin
         weld_tbl[weld_fill] = v;
         r.new_index         = OUT_W'(weld_fill);
         r.is_new            = 1'b1;
         weld_fill++;
      end else begin
         r.new_index = OUT_W'(DEPTH);
         r.overflow  = 1'b1;
      end
      r.unique_count = OUT_W'(weld_fill);
      if (last) begin
         weld_fill = 0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input rsp_type want,
                                  input rsp_type got);
      error_cnt++;
      if (error_cnt <= MAX_REPORTS) begin
         $display("%0t mismatch (%s): exp idx=%0d new=%0d ovf=%0d cnt=%0d",
                  $realtime, what, want.new_index, want.is_new, want.overflow,
                  want.unique_count);
         $display("%0t                  got idx=%0d new=%0d ovf=%0d cnt=%0d",
                  $realtime, got.new_index, got.is_new, got.overflow,
                  got.unique_count);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result receiver with random stalls
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // beat monitor: predict on request beats, check on result beats
   always @(posedge clock) begin : beat_monitor
      rsp_type      want;
      rsp_type      got;
      hand_exp_type h;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            want = weld_vertex({req_bus.coord_x, req_bus.coord_y, req_bus.coord_z},
                               req_bus.last_vertex);
            if (hand_q.size() != 0) begin
               h = hand_q.pop_front();
               if (h.typed) begin
                  want = h.want;
               end
            end
            remap_q.push_back(want);
            vertices_sent++;
            if (req_bus.last_vertex) begin
               sets_closed++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.new_index, rsp_bus.is_new, rsp_bus.overflow,
                    rsp_bus.unique_count};
            if (remap_q.size() == 0) begin
               report_mismatch("no result expected", '0, got);
            end else begin
               want = remap_q.pop_front();
               results_checked++;
               if (want.overflow) overflow_seen++;
               if (!want.is_new && !want.overflow) dup_seen++;
               if (got != want) begin
                  report_mismatch("field", want, got);
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t timeout: no beat for %0d cycles", $realtime, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // drive one vertex and hold it until the beat is taken
   task automatic send_vertex(input vertex_type v, input logic last, input bit typed,
                              input rsp_type want);
      hand_exp_type h;
      h.typed = typed;
      h.want  = want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      hand_q.push_back(h);
      req_bus.valid       <= 1'b1;
      req_bus.coord_x     <= v.x;
      req_bus.coord_y     <= v.y;
      req_bus.coord_z     <= v.z;
      req_bus.last_vertex <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold off the sender until every result is back
   // the queue is watched only once the monitor has queued the last request beat
   task automatic wait_results_home();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (remap_q.size() != 0) @(posedge clock);
   endtask

   // small set: repeats, one-bit near misses, corner words and fresh vertices
   task automatic send_set(input int len, input int reuse_pct);
      vertex_type seen [$];
      vertex_type v;
      int         pick;
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (seen.size() != 0 && pick < reuse_pct) begin
            v = seen[$urandom_range(seen.size() - 1)];
         end else if (seen.size() != 0 && pick < reuse_pct + 10) begin
            v = seen[$urandom_range(seen.size() - 1)];
            v = v ^ (96'd1 << $urandom_range(3 * COORD_W - 1));
         end else if (pick >= 96) begin
            v.x = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            v.y = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
            v.z = $urandom_range(1) ? 32'h0 : $urandom;
         end else begin
            v = {$urandom, $urandom, $urandom};
         end
         seen.push_back(v);
         send_vertex(v, k == len - 1, 1'b0, '0);
         random_items++;
      end
   endtask

   // full set: fill the table, then repeats while full and overflowing vertices
   task automatic send_full_set(input int tail);
      vertex_type seen [$];
      vertex_type v;
      for (int k = 0; k < DEPTH; k++) begin
         v = {$urandom, $urandom, $urandom};
         v.y[15:0] = k[15:0];
         seen.push_back(v);
         send_vertex(v, 1'b0, 1'b0, '0);
         random_items++;
      end
      for (int k = 0; k < tail; k++) begin
         if (k == 0 || (k != 1 && $urandom_range(1))) begin
            v = seen[$urandom_range(DEPTH - 1)];
         end else begin
            v = {$urandom, $urandom, $urandom};
         end
         send_vertex(v, k == tail - 1, 1'b0, '0);
         random_items++;
      end
   endtask

   // main sequence
   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.coord_x     <= '0;
      req_bus.coord_y     <= '0;
      req_bus.coord_z     <= '0;
      req_bus.last_vertex <= 1'b0;
      send_idle_pct = 7;
      sink_idle_pct = 46;
      weld_fill       = 0;
      random_items    = 0;
      vertices_sent   = 0;
      sets_closed     = 0;
      results_checked = 0;
      dup_seen        = 0;
      overflow_seen   = 0;
      error_cnt       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         send_vertex(dir_rows[i].v, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      end

      // random sets under three idling patterns
      for (int ph = 0; ph < 3; ph++) begin
         wait_results_home();
         case (ph)
            0: begin
               send_idle_pct = 7;
               sink_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               sink_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               sink_idle_pct = 0;
            end
         endcase
         if (ph != 1) begin
            send_full_set($urandom_range(20, 48));
         end
         while (random_items < (ph + 1) * PHASE_ITEMS) begin
            if ($urandom_range(7) == 0) begin
               send_set($urandom_range(1, 24), 0);
            end else begin
               send_set($urandom_range(1, 24), 30);
            end
         end
      end

      // drain and settle
      wait_results_home();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (remap_q.size() != 0) begin
         error_cnt++;
         $display("%0d results never arrived", remap_q.size());
      end

      $display("covered %0d vertices in %0d sets, %0d results checked",
               vertices_sent, sets_closed, results_checked);
      $display("repeats %0d, table overflows %0d, mismatches %0d",
               dup_seen, overflow_seen, error_cnt);
      if (error_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
